>>> src/overwrite_byte_ring_buffer_assert.svh
// Assertion macros for the byte ring buffer.
// Both sample on clk and are disabled while rst_n is low.
`ifndef OVERWRITE_BYTE_RING_BUFFER_ASSERT_SVH
`define OVERWRITE_BYTE_RING_BUFFER_ASSERT_SVH

// Same-cycle implication.
`define OBR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("obr assertion failed");

// Next-cycle implication.
`define OBR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("obr assertion failed");

`endif

>>> src/obr_pkg.sv
// ----------------------------------------------------------------------------
// obr_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package obr_pkg;

  // Ring depth; a power of two so pointers wrap by truncation.
  localparam int RING_BYTES = 1024;
  localparam int MAX_BURST  = 64;

  localparam int PTR_W      = $clog2(RING_BYTES);
  localparam int LVL_W      = PTR_W + 1;

  localparam int FUNC_W     = 2;
  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 7;
  localparam int BACK_IN_W  = 11;
  localparam int BACK_W     = CNT_W + BACK_IN_W;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_GET   = 2'd1,
    FUNC_DUMP  = 2'd2,
    FUNC_ENTRY = 2'd3
  } obr_func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ
  } obr_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic latch;        // capture a read request
    logic put;          // store one byte
    logic load_run;     // load start pointer and run length
    logic issue;        // read one byte of the run
    logic emit_status;  // send a single status result
    logic commit;       // consume the run (get only)
  } obr_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic in_is_put;
    logic check_err;
    logic run_last;
  } obr_stat_t;

endpackage

>>> src/obr_ctrl.sv
// ----------------------------------------------------------------------------
// obr_ctrl
// Request sequencer: store a put at once; accept, check, then stream a read one byte a cycle or send one status.
// ----------------------------------------------------------------------------
module obr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  obr_pkg::obr_stat_t stat,
  output obr_pkg::obr_cmd_t  cmd
);
  import obr_pkg::*;

  obr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (stat.in_is_put) begin
            cmd.put = 1'b1;
          end else begin
            cmd.latch = 1'b1;
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (stat.check_err) begin
          cmd.emit_status = 1'b1;
          state_nxt       = ST_IDLE;
        end else begin
          cmd.load_run = 1'b1;
          state_nxt    = ST_READ;
        end
      end
      ST_READ: begin
        cmd.issue = 1'b1;
        if (stat.run_last) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`include "overwrite_byte_ring_buffer_assert.svh"

  `OBR_ASSERT_NEXT(a_check_leaves, state_r == ST_CHECK, state_r == ST_IDLE || state_r == ST_READ)
  `OBR_ASSERT_NOW(a_put_only_idle, cmd.put, state_r == ST_IDLE && !busy)
  `OBR_ASSERT_NEXT(a_latch_to_check, cmd.latch, state_r == ST_CHECK)

endmodule

>>> src/obr_dpath.sv
// ----------------------------------------------------------------------------
// obr_dpath
// Byte store, pointers, fill level, request checks and result registers.
// ----------------------------------------------------------------------------
module obr_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [obr_pkg::FUNC_W-1:0]          in_func,
  input  logic [obr_pkg::BYTE_W-1:0]          in_write_byte,
  input  logic [obr_pkg::CNT_W-1:0]           in_byte_count,
  input  logic [obr_pkg::CNT_W-1:0]           in_entry_size,
  input  logic [obr_pkg::BACK_IN_W-1:0]       in_entry_back,
  input  obr_pkg::obr_cmd_t                   cmd,
  output obr_pkg::obr_stat_t                  stat,
  output logic                                out_valid,
  output logic [obr_pkg::BYTE_W-1:0]          out_read_byte,
  output logic                                out_status,
  output logic                                out_last
);
  import obr_pkg::*;

  logic [BYTE_W-1:0] mem [RING_BYTES];

  logic [PTR_W-1:0]  wp_r, rp_r, addr_r;
  logic [LVL_W-1:0]  fill_r;
  logic              ovw_r;
  obr_func_t         func_r;
  logic [CNT_W-1:0]  count_r, esize_r;
  logic              eback_zero_r;
  logic [BACK_W-1:0] back_r;
  logic [CNT_W-1:0]  rem_r;

  logic [BYTE_W-1:0] rdata_r;
  logic              valid_r, status_r, last_r;

  logic              full;
  logic              ovw_nxt;
  logic              err;
  logic [CNT_W-1:0]  run_len;
  logic [PTR_W-1:0]  run_start;

  // Store: one write port for put, one registered read port for the run.
  always_ff @(posedge clk) begin
    if (cmd.put) begin
      mem[wp_r] <= in_write_byte;
    end
    if (cmd.issue) begin
      rdata_r <= mem[addr_r];
    end
  end

  assign full    = (fill_r == LVL_W'(RING_BYTES));
  assign ovw_nxt = ovw_r | full;

  always_comb begin
    err       = 1'b0;
    run_len   = count_r;
    run_start = rp_r;
    case (func_r) inside
      FUNC_GET, FUNC_DUMP: begin
        err = (count_r == '0) || (LVL_W'(count_r) > fill_r) ||
              (count_r > CNT_W'(MAX_BURST));
      end
      FUNC_ENTRY: begin
        run_len   = esize_r;
        run_start = wp_r - back_r[PTR_W-1:0];
        err = (esize_r == '0) || eback_zero_r || (back_r > BACK_W'(fill_r)) ||
              (esize_r > CNT_W'(MAX_BURST));
      end
      default: begin
        err = 1'b0;
      end
    endcase
  end

  assign stat.in_is_put = (obr_func_t'(in_func) == FUNC_PUT);
  assign stat.check_err = err;
  assign stat.run_last  = (rem_r == CNT_W'(1));

  // Request capture; the entry product is registered before it is compared.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r       <= obr_func_t'(in_func);
      count_r      <= in_byte_count;
      esize_r      <= in_entry_size;
      eback_zero_r <= (in_entry_back == '0);
      back_r       <= BACK_W'(in_entry_size) * BACK_W'(in_entry_back);
    end
    if (cmd.load_run) begin
      addr_r <= run_start;
      rem_r  <= run_len;
    end else if (cmd.issue) begin
      addr_r <= addr_r + PTR_W'(1);
      rem_r  <= rem_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fill_r <= '0;
      ovw_r  <= 1'b0;
    end else if (cmd.put) begin
      wp_r  <= wp_r + PTR_W'(1);
      ovw_r <= ovw_nxt;
      if (ovw_nxt) begin
        fill_r <= LVL_W'(RING_BYTES);
        rp_r   <= wp_r + PTR_W'(1);
      end else begin
        fill_r <= fill_r + LVL_W'(1);
      end
    end else if (cmd.commit && func_r == FUNC_GET) begin
      rp_r   <= rp_r + PTR_W'(count_r);
      fill_r <= fill_r - LVL_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      status_r <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      valid_r  <= cmd.issue | cmd.emit_status;
      status_r <= cmd.emit_status;
      last_r   <= cmd.emit_status | (cmd.issue & stat.run_last);
    end
  end

  assign out_valid     = valid_r;
  assign out_status    = status_r;
  assign out_last      = last_r;
  assign out_read_byte = status_r ? '0 : rdata_r;

`include "overwrite_byte_ring_buffer_assert.svh"

  `OBR_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= LVL_W'(RING_BYTES))
  `OBR_ASSERT_NEXT(a_ovw_sticky, ovw_r, ovw_r)
  `OBR_ASSERT_NEXT(a_ovw_full, ovw_r && cmd.put, fill_r == LVL_W'(RING_BYTES))

endmodule

>>> src/overwrite_byte_ring_buffer.sv
// Put: taken at once, no result; busy stays low, next request may follow at once.
// Get, dump, get-entry: a check state, then one byte per cycle from the store read
// port through the output register; busy holds through the check and read states.
// A rejected read: one status strobe from the check state, busy only in that state.
// Reset clears pointers, fill level and overwrite mode; the store is not cleared.
// ----------------------------------------------------------------------------
// overwrite_byte_ring_buffer
// Byte ring buffer with put, get, dump and get-entry requests and a sticky
// overwrite mode once the ring has overflowed.
// ----------------------------------------------------------------------------
module overwrite_byte_ring_buffer (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel: accepted when start is high and busy is low
  input  logic                          start,
  output logic                          busy,
  input  logic [obr_pkg::FUNC_W-1:0]    in_func,
  input  logic [obr_pkg::BYTE_W-1:0]    in_write_byte,
  input  logic [obr_pkg::CNT_W-1:0]     in_byte_count,
  input  logic [obr_pkg::CNT_W-1:0]     in_entry_size,
  input  logic [obr_pkg::BACK_IN_W-1:0] in_entry_back,
  // result channel: one-cycle strobe, the receiver cannot stall
  output logic                          out_valid,
  output logic [obr_pkg::BYTE_W-1:0]    out_read_byte,
  output logic                          out_status,
  output logic                          out_last
);
  import obr_pkg::*;

  // Command and status between the sequencer and the datapath.
  obr_cmd_t  cmd;
  obr_stat_t stat;

  // Sequencer: decide when to store, check, stream and consume.
  obr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Datapath: the byte store, the ring pointers, the fill level and the
  // registered result; a read request is checked against the fill level
  // before any byte streams, so a rejected request never touches state.
  obr_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_func       (in_func),
    .in_write_byte (in_write_byte),
    .in_byte_count (in_byte_count),
    .in_entry_size (in_entry_size),
    .in_entry_back (in_entry_back),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_read_byte (out_read_byte),
    .out_status    (out_status),
    .out_last      (out_last)
  );

endmodule

>>> tb/sv/tb_overwrite_byte_ring_buffer.sv
// ----------------------------------------------------------------------------
// tb_overwrite_byte_ring_buffer
// Self-checking bench for the overwriting byte ring buffer: a queue of put,
// get, dump and get-entry requests feeds a clocked driver, a shadow model of
// the ring predicts every byte and status strobe, and a clocked monitor
// compares each strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_overwrite_byte_ring_buffer;
  timeunit 1ns;
  timeprecision 1ps;

  import obr_pkg::*;

  // One request as the driver presents it; drain holds it back until the
  // block has gone quiet.
  typedef struct {
    obr_func_t             func;
    logic [BYTE_W-1:0]     wbyte;
    logic [CNT_W-1:0]      cnt;
    logic [CNT_W-1:0]      esize;
    logic [BACK_IN_W-1:0]  eback;
    bit                    drain;
  } ring_req_t;

  // One result strobe.
  typedef struct {
    logic [BYTE_W-1:0] rd_byte;
    logic              status;
    logic              last;
  } ring_rsp_t;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  start         = 1'b0;
  logic [FUNC_W-1:0]     in_func       = '0;
  logic [BYTE_W-1:0]     in_write_byte = '0;
  logic [CNT_W-1:0]      in_byte_count = '0;
  logic [CNT_W-1:0]      in_entry_size = '0;
  logic [BACK_IN_W-1:0]  in_entry_back = '0;
  logic                  busy;
  logic                  out_valid;
  logic [BYTE_W-1:0]     out_read_byte;
  logic                  out_status;
  logic                  out_last;

  ring_req_t request_queue[$];
  ring_rsp_t expected_reads[$];

  // Shadow copy of the ring state, advanced as requests are accepted.
  logic [BYTE_W-1:0] ring_mem [RING_BYTES];
  int                wr_ptr   = 0;
  int                rd_ptr   = 0;
  int                fill_lvl = 0;
  bit                ovw_mode = 1'b0;

  // Fill estimate used only while building the request list, so that most
  // reads ask for what is actually stored.
  int plan_fill  = 0;
  bit plan_ovw   = 1'b0;
  bit drain_next = 1'b0;

  int gap_left = 0;
  int errors   = 0;

  overwrite_byte_ring_buffer dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_write_byte (in_write_byte),
    .in_byte_count (in_byte_count),
    .in_entry_size (in_entry_size),
    .in_entry_back (in_entry_back),
    .out_valid     (out_valid),
    .out_read_byte (out_read_byte),
    .out_status    (out_status),
    .out_last      (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Ring prediction: update the shadow state for one accepted request and
  // queue the strobes it must produce.
  // --------------------------------------------------------------------------
  task automatic predict_ring_read(input ring_req_t r);
    int  run_start;
    int  run_len;
    int  back;
    bit  reject;
    ring_rsp_t rsp;
    run_start = 0;
    run_len   = 0;
    reject    = 1'b0;
    case (r.func)
      FUNC_PUT: begin
        ring_mem[wr_ptr] = r.wbyte;
        wr_ptr = (wr_ptr + 1) % RING_BYTES;
        // A put into a full ring turns on overwrite mode for good.
        if (fill_lvl >= RING_BYTES) ovw_mode = 1'b1;
        else fill_lvl++;
        // In overwrite mode the newest RING_BYTES bytes are readable again,
        // even after gets have consumed some of them.
        if (ovw_mode) begin
          fill_lvl = RING_BYTES;
          rd_ptr   = wr_ptr;
        end
      end
      FUNC_GET, FUNC_DUMP: begin
        run_len   = int'(r.cnt);
        run_start = rd_ptr;
        reject    = (run_len == 0) || (run_len > fill_lvl) || (run_len > MAX_BURST);
        if (!reject && r.func == FUNC_GET) begin
          rd_ptr   = (rd_ptr + run_len) % RING_BYTES;
          fill_lvl = fill_lvl - run_len;
        end
      end
      default: begin
        // Get-entry: entry_size bytes starting entry_size * entry_back bytes
        // behind the write end, wrapping around the ring end.
        run_len   = int'(r.esize);
        back      = int'(r.esize) * int'(r.eback);
        reject    = (r.esize == 0) || (r.eback == 0) || (back > fill_lvl) ||
                    (run_len > MAX_BURST);
        if (!reject) run_start = (wr_ptr + RING_BYTES - back) % RING_BYTES;
      end
    endcase
    if (r.func != FUNC_PUT) begin
      if (reject) begin
        // A read that cannot be served: one status strobe, state untouched.
        rsp.rd_byte = '0;
        rsp.status  = 1'b1;
        rsp.last    = 1'b1;
        expected_reads.push_back(rsp);
      end else begin
        for (int k = 0; k < run_len; k++) begin
          rsp.rd_byte = ring_mem[(run_start + k) % RING_BYTES];
          rsp.status  = 1'b0;
          rsp.last    = (k == run_len - 1);
          expected_reads.push_back(rsp);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Request list construction.
  // --------------------------------------------------------------------------
  function automatic ring_req_t make_req(input obr_func_t f, input int wb, input int cnt,
                                         input int es, input int eb);
    ring_req_t r;
    r.func  = f;
    r.wbyte = BYTE_W'(wb);
    r.cnt   = CNT_W'(cnt);
    r.esize = CNT_W'(es);
    r.eback = BACK_IN_W'(eb);
    r.drain = 1'b0;
    return r;
  endfunction

  // Append a request and advance the fill estimate.
  task automatic queue_request(input ring_req_t r);
    r.drain   = r.drain | drain_next;
    drain_next = 1'b0;
    if (r.func == FUNC_PUT) begin
      if (plan_fill >= RING_BYTES) plan_ovw = 1'b1;
      else plan_fill++;
      if (plan_ovw) plan_fill = RING_BYTES;
    end else if (r.func == FUNC_GET && r.cnt != 0 && int'(r.cnt) <= plan_fill &&
                 r.cnt <= MAX_BURST) begin
      plan_fill = plan_fill - int'(r.cnt);
    end
    request_queue.push_back(r);
  endtask

  // Random request: mostly well-formed reads sized to the stored bytes,
  // some noise over the full field ranges. Unused fields carry random bits.
  task automatic add_random_request(input int put_pct);
    ring_req_t r;
    int lim;
    int esz;
    int ebk;
    r.wbyte = BYTE_W'($urandom_range(0, 255));
    r.cnt   = CNT_W'($urandom_range(0, 127));
    r.esize = CNT_W'($urandom_range(0, 127));
    r.eback = BACK_IN_W'($urandom_range(0, 2047));
    r.drain = ($urandom_range(0, 99) == 0);
    if ($urandom_range(0, 99) < put_pct) begin
      r.func = FUNC_PUT;
    end else begin
      r.func = obr_func_t'($urandom_range(1, 3));
      if (plan_fill > 0 && $urandom_range(0, 99) < 85) begin
        lim = (plan_fill < MAX_BURST) ? plan_fill : MAX_BURST;
        if (lim > 16 && $urandom_range(0, 2) != 0) lim = 16;
        if (r.func == FUNC_ENTRY) begin
          esz = int'($urandom_range(1, lim));
          ebk = plan_fill / esz;
          // Now and then reach back to the very oldest entry.
          if ($urandom_range(0, 9) != 0) ebk = int'($urandom_range(1, ebk));
          r.esize = CNT_W'(esz);
          r.eback = BACK_IN_W'(ebk);
        end else begin
          r.cnt = CNT_W'($urandom_range(1, lim));
        end
      end
    end
    queue_request(r);
  endtask

  // --------------------------------------------------------------------------
  // Driver: present the front request, hold it until accepted, then either
  // advance to the next one or insert a random idle burst.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    bit took;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      if (took) begin
        predict_ring_read(request_queue[0]);
        void'(request_queue.pop_front());
        // Idle only while more than the final stretch of requests remains.
        if (request_queue.size() > 100 && $urandom_range(0, 9) == 0)
          gap_left = $urandom_range(1, 11);
      end
      if (start && !took) begin
        // Hold the request until the block takes it.
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (request_queue.size() > 0 &&
                   !(request_queue[0].drain && (expected_reads.size() > 0 || busy))) begin
        start         <= 1'b1;
        in_func       <= request_queue[0].func;
        in_write_byte <= request_queue[0].wbyte;
        in_byte_count <= request_queue[0].cnt;
        in_entry_size <= request_queue[0].esize;
        in_entry_back <= request_queue[0].eback;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every strobe is taken at the edge that ends its cycle and is
  // compared with the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    ring_rsp_t exp_rsp;
    if (rst_n && out_valid) begin
      if (expected_reads.size() == 0) begin
        $error("unexpected result: read_byte %0h status %0b last %0b",
               out_read_byte, out_status, out_last);
        errors++;
      end else begin
        exp_rsp = expected_reads.pop_front();
        if (out_read_byte !== exp_rsp.rd_byte) begin
          $error("read_byte mismatch: expected %0h, actual %0h",
                 exp_rsp.rd_byte, out_read_byte);
          errors++;
        end
        if (out_status !== exp_rsp.status) begin
          $error("status mismatch: expected %0b, actual %0b", exp_rsp.status, out_status);
          errors++;
        end
        if (out_last !== exp_rsp.last) begin
          $error("last mismatch: expected %0b, actual %0b", exp_rsp.last, out_last);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of test.
  // --------------------------------------------------------------------------
  initial begin
    logic [BYTE_W-1:0] seed_bytes [8];
    seed_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA};

    // Directed: empty ring, rejected reads of every kind, then a short run.
    queue_request(make_req(FUNC_GET,   0, 0,   0,    0));   // empty request
    queue_request(make_req(FUNC_DUMP,  0, 1,   0,    0));   // nothing stored
    queue_request(make_req(FUNC_ENTRY, 0, 0,   1,    1));   // nothing stored
    foreach (seed_bytes[i])
      queue_request(make_req(FUNC_PUT, int'(seed_bytes[i]), 0, 0, 0));
    queue_request(make_req(FUNC_DUMP,  0, 8,   0,    0));   // all stored bytes, kept
    queue_request(make_req(FUNC_DUMP,  0, 9,   0,    0));   // one too many
    queue_request(make_req(FUNC_GET,   0, 65,  0,    0));   // burst too long
    queue_request(make_req(FUNC_GET,   0, 127, 0,    0));
    queue_request(make_req(FUNC_ENTRY, 0, 0,   0,    1));   // zero entry size
    queue_request(make_req(FUNC_ENTRY, 0, 0,   2,    0));   // zero entries back
    queue_request(make_req(FUNC_ENTRY, 0, 0,   2,    4));   // oldest entry
    queue_request(make_req(FUNC_ENTRY, 0, 0,   3,    3));   // reaches past fill
    queue_request(make_req(FUNC_ENTRY, 0, 0,   127,  2047));
    queue_request(make_req(FUNC_GET,   0, 3,   0,    0));   // consume part
    queue_request(make_req(FUNC_ENTRY, 0, 0,   1,    6));   // consumed bytes gone
    queue_request(make_req(FUNC_GET,   0, 5,   0,    0));   // consume the rest
    queue_request(make_req(FUNC_DUMP,  0, 1,   0,    0));   // empty again

    // Random mix below the overflow point.
    drain_next = 1'b1;
    repeat (260) add_random_request(60);

    // Fill the ring past full to switch on overwrite mode, and wrap a bit.
    drain_next = 1'b1;
    while (!plan_ovw) add_random_request(100);
    repeat (20) add_random_request(100);

    // Random mix in overwrite mode: gets consume, the next put restores.
    drain_next = 1'b1;
    repeat (240) add_random_request(45);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every request to be taken, then for the ring to go quiet.
    while (request_queue.size() > 0) @(posedge clk);
    while (expected_reads.size() > 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
